>>> hdl/camc_pkg.sv
package camc_pkg;

  localparam int unsigned CoW      = 12;
  localparam int unsigned Co2W     = 16;
  localparam int unsigned SeatW    = 4;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCoAlarm       = 4'd0;
  localparam logic [CfgIdxW-1:0] RegCo2Alarm      = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCoActive      = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCoDiff        = 4'd3;
  localparam logic [CfgIdxW-1:0] RegCoRise        = 4'd4;
  localparam logic [CfgIdxW-1:0] RegCo2High       = 4'd5;
  localparam logic [CfgIdxW-1:0] RegCo2OutsideHigh = 4'd6;
  localparam logic [CfgIdxW-1:0] RegCo2BaseThresh = 4'd7;

  // Register reset values
  localparam logic [CoW-1:0]  CoAlarmRst        = 12'd1000;
  localparam logic [Co2W-1:0] Co2AlarmRst       = 16'd10000;
  localparam logic [CoW-1:0]  CoActiveRst       = 12'd30;
  localparam logic [CoW-1:0]  CoDiffRst         = 12'd10;
  localparam logic [CoW-1:0]  CoRiseRst         = 12'd20;
  localparam logic [Co2W-1:0] Co2HighRst        = 16'd1300;
  localparam logic [Co2W-1:0] Co2OutsideHighRst = 16'd2000;
  localparam logic [Co2W-1:0] Co2BaseThreshRst  = 16'd550;

  // Threshold step per occupied seat
  localparam logic [7:0] SeatStepPpm = 8'd150;

  typedef enum logic [1:0] {
    MODE_RECIRC = 2'd0,
    MODE_FRESH  = 2'd1,
    MODE_OFF    = 2'd2
  } ac_mode_e;

  typedef struct packed {
    logic [CoW-1:0]   co_inside_ppm;
    logic [CoW-1:0]   co_outside_ppm;
    logic [Co2W-1:0]  co2_inside_ppm;
    logic [Co2W-1:0]  co2_outside_ppm;
    logic [SeatW-1:0] seat_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      ac_mode;
    logic            holding;
    logic [Co2W-1:0] co2_threshold;
  } out_item_t;

endpackage

>>> hdl/camc_if.sv
interface camc_in_if;
  import camc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface camc_out_if;
  import camc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cabin_air_mode_controller_unit.sv
// Channel    Dir  Payload                                        Handshake
// in_ch      in   co/co2 inside/outside ppm, seat_bits           valid/ready
// out_ch     out  ac_mode, holding, co2_threshold                valid/ready
// cfg        in   cfg_idx_i, cfg_data_i                          cfg_we_i, no wait
//
// One request is taken per cycle while out_ch is not stalled; its result passes through the
// input register, then the result register. The mode update is one pass of compares.
// Reset (rst_ni low, async) clears the mode state and loads the register defaults.
// A stall on out_ch holds the result register, then the input register, then in_ch.
module cabin_air_mode_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  camc_in_if.sink                       in_ch,
  camc_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [camc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [camc_pkg::CfgDataW-1:0] cfg_data_i
);
  import camc_pkg::*;

  typedef struct packed {
    logic           armed;
    logic [CoW-1:0] base;
    logic           trip;
  } bl_t;

  // Take the baseline on first detection; trip on a rise past it
  function automatic bl_t bl_check(input logic armed, input logic [CoW-1:0] base,
                                   input logic [CoW-1:0] co, input logic [CoW-1:0] rise);
    bl_t r;
    r.armed = armed;
    r.base  = base;
    r.trip  = 1'b0;
    if (!armed) begin
      r.base  = co;
      r.armed = 1'b1;
    end
    if ({1'b0, co} > ({1'b0, r.base} + {1'b0, rise})) begin
      r.trip  = 1'b1;
      r.base  = '0;
      r.armed = 1'b0;
    end
    return r;
  endfunction

  // Configuration registers
  logic [CoW-1:0]  co_alarm_q, co_active_q, co_diff_q, co_rise_q;
  logic [Co2W-1:0] co2_alarm_q, co2_high_q, co2_out_high_q, co2_base_thr_q;

  // Mode state
  ac_mode_e       mode_q, mode_d;
  logic           armed_q, armed_d;
  logic [CoW-1:0] base_q, base_d;
  logic           vent_q, vent_d;
  logic           hold_q, hold_d;

  // Pipeline
  logic      s1_valid_q;
  in_item_t  s1_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  out_item_t res;
  logic      s2_load, s1_fire;

  logic [2:0]      seat_cnt;
  logic [9:0]      seat_add;
  logic [Co2W:0]   thr_sum;
  logic [Co2W-1:0] thr;
  bl_t             bl;

  assign s2_load      = !out_valid_q || out_ch.ready;
  assign s1_fire      = s1_valid_q && s2_load;
  assign in_ch.ready  = !s1_valid_q || s2_load;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_alarm_q     <= CoAlarmRst;
      co2_alarm_q    <= Co2AlarmRst;
      co_active_q    <= CoActiveRst;
      co_diff_q      <= CoDiffRst;
      co_rise_q      <= CoRiseRst;
      co2_high_q     <= Co2HighRst;
      co2_out_high_q <= Co2OutsideHighRst;
      co2_base_thr_q <= Co2BaseThreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCoAlarm:        co_alarm_q     <= cfg_data_i[CoW-1:0];
        RegCo2Alarm:       co2_alarm_q    <= cfg_data_i[Co2W-1:0];
        RegCoActive:       co_active_q    <= cfg_data_i[CoW-1:0];
        RegCoDiff:         co_diff_q      <= cfg_data_i[CoW-1:0];
        RegCoRise:         co_rise_q      <= cfg_data_i[CoW-1:0];
        RegCo2High:        co2_high_q     <= cfg_data_i[Co2W-1:0];
        RegCo2OutsideHigh: co2_out_high_q <= cfg_data_i[Co2W-1:0];
        RegCo2BaseThresh:  co2_base_thr_q <= cfg_data_i[Co2W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  // Occupancy threshold, saturated
  always_comb begin
    seat_cnt = {2'b0, s1_data_q.seat_bits[0]} + {2'b0, s1_data_q.seat_bits[1]}
             + {2'b0, s1_data_q.seat_bits[2]} + {2'b0, s1_data_q.seat_bits[3]};
    seat_add = 10'({7'b0, seat_cnt} * {2'b0, SeatStepPpm});
    thr_sum  = {1'b0, co2_base_thr_q} + {7'b0, seat_add};
    thr      = thr_sum[Co2W] ? '1 : thr_sum[Co2W-1:0];
  end

  always_comb begin
    mode_d  = mode_q;
    armed_d = armed_q;
    base_d  = base_q;
    vent_d  = vent_q;
    hold_d  = hold_q;
    bl      = '0;
    if (hold_q) begin
      if (s1_data_q.co2_outside_ppm <= co2_high_q) begin
        hold_d = 1'b0;
        mode_d = MODE_FRESH;
      end
    end else begin
      if (s1_data_q.co_inside_ppm >= co_alarm_q || s1_data_q.co2_inside_ppm >= co2_alarm_q) begin
        mode_d = MODE_OFF;
      end
      if (s1_data_q.co_inside_ppm >= co_active_q) begin
        // inside much worse: take fresh air
        if ({1'b0, s1_data_q.co_inside_ppm} >=
            ({1'b0, s1_data_q.co_outside_ppm} + {1'b0, co_diff_q})) begin
          if (mode_d == MODE_RECIRC) mode_d = MODE_FRESH;
          if (mode_d == MODE_FRESH) begin
            bl      = bl_check(armed_d, base_d, s1_data_q.co_inside_ppm, co_rise_q);
            armed_d = bl.armed;
            base_d  = bl.base;
            if (bl.trip) mode_d = MODE_OFF;
          end
        end
        // outside much worse: recirculate; sees the first case's update
        if ({1'b0, s1_data_q.co_outside_ppm} >=
            ({1'b0, s1_data_q.co_inside_ppm} + {1'b0, co_diff_q})) begin
          if (mode_d == MODE_FRESH) mode_d = MODE_RECIRC;
          if (mode_d == MODE_RECIRC) begin
            bl      = bl_check(armed_d, base_d, s1_data_q.co_inside_ppm, co_rise_q);
            armed_d = bl.armed;
            base_d  = bl.base;
            if (bl.trip) mode_d = MODE_OFF;
          end
        end
      end else begin
        if (s1_data_q.co2_inside_ppm >= co2_high_q) begin
          if (mode_d == MODE_RECIRC) begin
            mode_d = MODE_FRESH;
            vent_d = 1'b1;
          end
          if (mode_d == MODE_FRESH && !vent_d &&
              s1_data_q.co2_outside_ppm >= co2_out_high_q &&
              s1_data_q.co2_outside_ppm > co2_high_q) begin
            mode_d = MODE_RECIRC;
            hold_d = 1'b1;
          end
        end
        if (vent_d && s1_data_q.co2_inside_ppm < thr) begin
          mode_d = MODE_RECIRC;
          vent_d = 1'b0;
        end
      end
    end
    res.ac_mode       = mode_d;
    res.holding       = hold_d;
    res.co2_threshold = thr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RECIRC;
      armed_q     <= 1'b0;
      base_q      <= '0;
      vent_q      <= 1'b0;
      hold_q      <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        mode_q  <= mode_d;
        armed_q <= armed_d;
        base_q  <= base_d;
        vent_q  <= vent_d;
        hold_q  <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_q <= in_ch.data;
    end
    if (s1_fire) begin
      out_data_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_hold_recirc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> mode_q == MODE_RECIRC)
    else $error("hold active outside recirculation");

  a_vent_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vent_q |-> !hold_q)
    else $error("venting and hold both set");

  a_base_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> base_q == '0)
    else $error("baseline kept while disarmed");

  a_stall_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |=> $stable(mode_q) && $stable(vent_q) && $stable(hold_q))
    else $error("mode state moved during output stall");
`endif

endmodule
